>>> rtl/plsh_pkg.sv
// Package for the p-stable LSH hash engine: payload structs, sizes, codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package plsh_pkg;

  localparam int TABLES_MAX = 16;
  localparam int FUNCS_MAX  = 8;
  localparam int DIMS_MAX   = 128;
  localparam int TW = $clog2(TABLES_MAX);
  localparam int FW = $clog2(FUNCS_MAX);
  localparam int DW = $clog2(DIMS_MAX);
  localparam int CW = TW + FW + DW;

  localparam logic [1:0] CMD_COEF   = 2'd0;
  localparam logic [1:0] CMD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TABLES = 2'd1;
  localparam logic [1:0] REG_FUNCS  = 2'd2;
  localparam logic [1:0] REG_DIMS   = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         table_index;
    logic [2:0]         func_index;
    logic [6:0]         dim_index;
    logic signed [15:0] coef_value;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_table;
    logic signed [63:0] hash_value;
    logic               last_of_point;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MAC, ST_DRAIN, ST_DIV_START, ST_DIV, ST_MUL, ST_ACC, ST_EMIT,
    ST_OUT
  } plsh_state_t;

  typedef struct packed {
    logic          clr_dot;
    logic          rd_en;
    logic [DW-1:0] rd_dim;
    logic [TW-1:0] rd_tab;
    logic [FW-1:0] rd_fn;
    logic          mac_en;
    logic          div_start;
    logic          mul_en;
    logic          acc_en;
    logic          clr_hash;
  } plsh_cmd_t;

  typedef struct packed {
    logic div_busy;
  } plsh_sts_t;

endpackage

>>> rtl/plsh_datapath.sv
// Datapath of the LSH hash engine: coefficient, point and weight stores,
// the shared MAC, a restoring divider, and the weighted saturating accumulator.
// Depends on plsh_pkg.
module plsh_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_coef,
  input  logic                 wr_weight,
  input  logic                 wr_point,
  input  plsh_pkg::in_item_t   wr_item,
  input  logic [30:0]          bucket_width,
  input  plsh_pkg::plsh_cmd_t  cmd,
  output plsh_pkg::plsh_sts_t  sts,
  output logic signed [63:0]   hash_value
);
  import plsh_pkg::*;

  logic signed [15:0] coef_mem [0:(1<<CW)-1];
  logic signed [31:0] point_mem [0:DIMS_MAX-1];
  logic signed [15:0] weight_mem [0:FUNCS_MAX-1];
  logic signed [15:0] coef_rd_r;
  logic signed [31:0] pt_rd_r;
  logic signed [47:0] prod_r;
  logic signed [63:0] dot_r;
  logic [63:0] rem_r, quo_r;
  logic [6:0]  div_cnt_r;
  logic        div_busy_r, neg_r;
  logic signed [31:0] bucket_r;
  logic signed [47:0] wprod_r;
  logic signed [63:0] hash_r;
  logic [44:0] divisor;
  logic [64:0] trial;
  logic [63:0] q_adj;
  logic signed [64:0] sum;

  always_ff @(posedge clk) begin
    if (wr_coef) begin
      coef_mem[{wr_item.table_index, wr_item.func_index, wr_item.dim_index}] <=
        wr_item.coef_value;
    end
    if (wr_point) begin
      point_mem[wr_item.dim_index] <= wr_item.sample_value;
    end
    if (wr_weight) begin
      weight_mem[wr_item.func_index] <= wr_item.coef_value;
    end
    if (cmd.rd_en) begin
      coef_rd_r <= coef_mem[{cmd.rd_tab, cmd.rd_fn, cmd.rd_dim}];
      pt_rd_r   <= point_mem[cmd.rd_dim];
    end
  end

  assign divisor = {(bucket_width == 31'd0) ? 31'd1 : bucket_width, 14'd0};
  assign trial   = {rem_r, quo_r[63]} - {20'd0, divisor};
  assign q_adj   = (neg_r && rem_r != 64'd0) ? quo_r + 64'd1 : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == 7'd63) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= pt_rd_r * coef_rd_r;
    if (cmd.clr_dot) begin
      dot_r <= '0;
    end else if (cmd.mac_en) begin
      dot_r <= dot_r + 64'(prod_r);
    end
    if (cmd.div_start) begin
      neg_r     <= dot_r[63];
      quo_r     <= dot_r[63] ? 64'(-dot_r) : dot_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 7'd1;
      if (!trial[64]) begin
        rem_r <= trial[63:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[62:0], quo_r[63]};
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (cmd.mul_en) begin
      if (neg_r) begin
        bucket_r <= (q_adj > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q_adj);
      end else begin
        bucket_r <= (q_adj > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q_adj[31:0];
      end
    end
    wprod_r <= bucket_r * weight_mem[cmd.rd_fn];
    if (cmd.clr_hash) begin
      hash_r <= '0;
    end else if (cmd.acc_en) begin
      if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
        hash_r <= 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (sum < -65'sh0_8000_0000_0000_0000) begin
        hash_r <= 64'sh8000_0000_0000_0000;
      end else begin
        hash_r <= sum[63:0];
      end
    end
  end

  assign sum = 65'(hash_r) + 65'(wprod_r);
  assign sts.div_busy = div_busy_r;
  assign hash_value = hash_r;

endmodule

>>> rtl/plsh_controller.sv
// Controller state machine of the LSH hash engine: walks tables, functions
// and dimensions, sequences MAC, divider and accumulator, and emits items.
// Depends on plsh_pkg.
module plsh_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [4:0]           tables_in_use,
  input  logic [3:0]           funcs_in_use,
  input  logic [7:0]           dims_in_use,
  input  plsh_pkg::plsh_sts_t  sts,
  output plsh_pkg::plsh_cmd_t  cmd,
  output logic                 busy,
  output logic                 emit,
  output logic [3:0]           emit_table,
  output logic                 emit_last,
  input  logic                 emit_done
);
  import plsh_pkg::*;

  plsh_state_t state_r, state_nxt;
  logic [TW-1:0] tab_r, tab_nxt, tab_last;
  logic [FW-1:0] fn_r, fn_nxt, fn_last;
  logic [DW-1:0] dim_r, dim_nxt, dim_last;

  assign tab_last = (tables_in_use == 5'd0) ? '0 :
                    (tables_in_use > 5'(TABLES_MAX)) ? TW'(TABLES_MAX-1) :
                    TW'(tables_in_use - 5'd1);
  assign fn_last  = (funcs_in_use == 4'd0) ? '0 :
                    (funcs_in_use > 4'(FUNCS_MAX)) ? FW'(FUNCS_MAX-1) :
                    FW'(funcs_in_use - 4'd1);
  assign dim_last = (dims_in_use == 8'd0) ? '0 :
                    (dims_in_use > 8'(DIMS_MAX)) ? DW'(DIMS_MAX-1) :
                    DW'(dims_in_use - 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tab_r   <= '0;
      fn_r    <= '0;
      dim_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tab_r   <= tab_nxt;
      fn_r    <= fn_nxt;
      dim_r   <= dim_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tab_nxt   = tab_r;
    fn_nxt    = fn_r;
    dim_nxt   = dim_r;
    cmd       = '0;
    cmd.rd_tab = tab_r;
    cmd.rd_fn  = fn_r;
    cmd.rd_dim = dim_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          tab_nxt = '0;
          fn_nxt  = '0;
          dim_nxt = '0;
          cmd.clr_dot  = 1'b1;
          cmd.clr_hash = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.rd_en = 1'b1;
        if (dim_r != '0) begin
          cmd.mac_en = 1'b1;
        end
        if (dim_r == dim_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          dim_nxt = dim_r + 1'b1;
          cmd.rd_dim = dim_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd.mac_en = 1'b1;
        state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!sts.div_busy) begin
          cmd.mul_en = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.acc_en = 1'b1;
        cmd.clr_dot = 1'b1;
        dim_nxt = '0;
        if (fn_r == fn_last) begin
          state_nxt = ST_OUT;
          fn_nxt = '0;
        end else begin
          fn_nxt = fn_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        if (emit_done) begin
          cmd.clr_hash = 1'b1;
          if (tab_r != tab_last) begin
            tab_nxt = tab_r + 1'b1;
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign emit       = (state_r == ST_OUT);
  assign emit_table = 4'(tab_r);
  assign emit_last  = (tab_r == tab_last);
  assign busy       = (state_r != ST_IDLE);

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == ST_IDLE) else $error("start while busy");
  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> !sts.div_busy) else $error("bucket taken mid-divide");
  a_div_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> $past(state_r) == ST_DIV_START || $past(state_r) == ST_DIV)
    else $error("divide started out of order");
`endif

endmodule

>>> rtl/pstable_lsh_hash_engine_core.sv
// Top level of the p-stable LSH hash engine: input decode, configuration
// registers, output register. Depends on plsh_pkg, plsh_controller, plsh_datapath.
//
//  channel | ports                          | role
//  in      | in_valid in_ready in_data      | loads and coordinates
//  out     | out_valid out_ready out_data   | one hash per table
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// Loads and coordinates are accepted only while no run is pending or active. The last
// coordinate sets a registered start for a run on the shared MAC and 64-step divider.
// Reset is synchronous and clears control state; stores are undefined until
// written. A stalled output holds the run before the next table is emitted.
module pstable_lsh_hash_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plsh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plsh_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import plsh_pkg::*;

  logic [30:0] width_r;
  logic [4:0]  tables_r;
  logic [3:0]  funcs_r;
  logic [7:0]  dims_r;
  logic        acc, busy, start, emit, emit_last, emit_done;
  logic [3:0]  emit_table;
  logic [DW-1:0] dim_last;
  logic        out_valid_r, pend_r;
  out_item_t   out_r;
  plsh_cmd_t   cmd;
  plsh_sts_t   sts;
  logic signed [63:0] hash_value;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && !pend_r;
  assign acc       = in_valid && in_ready;
  assign dim_last  = (dims_r == 8'd0) ? '0 :
                     (dims_r > 8'(DIMS_MAX)) ? DW'(DIMS_MAX-1) : DW'(dims_r - 8'd1);
  assign start     = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 31'd262144;
      tables_r <= 5'd16;
      funcs_r  <= 4'd8;
      dims_r   <= 8'd128;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[30:0];
        REG_TABLES: tables_r <= cfg_data[4:0];
        REG_FUNCS:  funcs_r  <= cfg_data[3:0];
        REG_DIMS:   dims_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= acc && in_data.cmd == CMD_SAMPLE && in_data.dim_index == dim_last;
      if (emit_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign emit_done = emit && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (emit_done) begin
      out_r.out_table     <= emit_table;
      out_r.hash_value    <= hash_value;
      out_r.last_of_point <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  plsh_controller u_ctrl (
    .clk, .rst_n, .start,
    .tables_in_use(tables_r), .funcs_in_use(funcs_r), .dims_in_use(dims_r),
    .sts, .cmd, .busy, .emit, .emit_table, .emit_last, .emit_done
  );

  plsh_datapath u_dp (
    .clk, .rst_n,
    .wr_coef(acc && in_data.cmd == CMD_COEF),
    .wr_weight(acc && in_data.cmd == CMD_WEIGHT),
    .wr_point(acc && in_data.cmd == CMD_SAMPLE),
    .wr_item(in_data), .bucket_width(width_r),
    .cmd, .sts, .hash_value
  );

endmodule

>>> tb/pstable_lsh_hash_engine_core_tb.sv
// Self-checking testbench for the p-stable LSH hash engine core: it drives loads,
// coordinates and register writes, and checks every hash item against a predictor.
// Depends on plsh_pkg and pstable_lsh_hash_engine_core.
module pstable_lsh_hash_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plsh_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 100000;

  class lsh_hash_model;
    logic [30:0] width_q;
    logic [4:0] tables_q;
    logic [3:0] funcs_q;
    logic [7:0] dims_q;
    logic signed [31:0] point[DIMS_MAX];
    logic signed [15:0] coef[TABLES_MAX * FUNCS_MAX * DIMS_MAX];
    logic signed [15:0] weight[FUNCS_MAX];
    bit point_ok[DIMS_MAX];
    bit coef_ok[TABLES_MAX * FUNCS_MAX * DIMS_MAX];
    bit weight_ok[FUNCS_MAX];
    out_item_t pending_hashes[$];
    int errors;
    int points;
    int hashes;

    function new();
      width_q = 31'd262144;
      tables_q = 5'd16;
      funcs_q = 4'd8;
      dims_q = 8'd128;
      errors = 0;
      points = 0;
      hashes = 0;
    endfunction

    function int clamp(int v, int max);
      if (v == 0) return 1;
      return (v > max) ? max : v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_WIDTH: width_q = data[30:0];
        REG_TABLES: tables_q = data[4:0];
        REG_FUNCS: funcs_q = data[3:0];
        REG_DIMS: dims_q = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      int nl, nk, nd, base;
      longint dot, divisor, bucket;
      logic signed [64:0] sum;
      out_item_t res;
      case (it.cmd)
        CMD_COEF: begin
          base = (it.table_index * FUNCS_MAX + it.func_index) * DIMS_MAX + it.dim_index;
          coef[base] = it.coef_value;
          coef_ok[base] = 1'b1;
        end
        CMD_WEIGHT: begin
          weight[it.func_index] = it.coef_value;
          weight_ok[it.func_index] = 1'b1;
        end
        CMD_SAMPLE: begin
          point[it.dim_index] = it.sample_value;
          point_ok[it.dim_index] = 1'b1;
          nd = clamp(dims_q, DIMS_MAX);
          if (it.dim_index == nd - 1) begin
            nl = clamp(tables_q, TABLES_MAX);
            nk = clamp(funcs_q, FUNCS_MAX);
            divisor = ((width_q == 0) ? 64'sd1 : longint'(width_q)) * 16384;
            points++;
            for (int l = 0; l < nl; l++) begin
              sum = '0;
              for (int k = 0; k < nk; k++) begin
                base = (l * FUNCS_MAX + k) * DIMS_MAX;
                dot = 0;
                for (int i = 0; i < nd; i++) dot += longint'(point[i]) * longint'(coef[base + i]);
                bucket = dot / divisor;
                if ((dot % divisor) != 0 && dot < 0) bucket -= 1;
                if (bucket > 64'sd2147483647) bucket = 64'sd2147483647;
                if (bucket < -64'sd2147483648) bucket = -64'sd2147483648;
                sum = sum + 65'(bucket * longint'(weight[k]));
                if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum = 65'sh0_7FFF_FFFF_FFFF_FFFF;
                if (sum < -65'sh0_8000_0000_0000_0000) sum = -65'sh0_8000_0000_0000_0000;
              end
              res.out_table = l[3:0];
              res.hash_value = sum[63:0];
              res.last_of_point = (l == nl - 1);
              pending_hashes.insert(pending_hashes.size(), res);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [63:0] exp_v, logic [63:0] got_v);
      $display("Mismatch in %s: expected %h, got %h at %0t", what, exp_v, got_v, $time);
      errors++;
    endtask

    task check_hash(out_item_t got);
      out_item_t exp_r;
      if (pending_hashes.size() == 0) begin
        report("unexpected hash item", 64'd0, got.hash_value);
        return;
      end
      exp_r = pending_hashes.pop_front();
      hashes++;
      if (got.out_table !== exp_r.out_table)
        report("out_table", 64'(exp_r.out_table), 64'(got.out_table));
      if (got.hash_value !== exp_r.hash_value)
        report("hash_value", exp_r.hash_value, got.hash_value);
      if (got.last_of_point !== exp_r.last_of_point)
        report("last_of_point", 64'(exp_r.last_of_point), 64'(got.last_of_point));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  lsh_hash_model model = new();
  bit out_idling = 1'b1;
  bit in_idling = 1'b1;
  int stall_cycles = 0;
  int seq_dim = 0;

  always #5 clk = ~clk;

  pstable_lsh_hash_engine_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = out_idling ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      model.check_hash(out_data);
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = in_idling ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.note_item(it);
  endtask

  task automatic write_regs(logic [31:0] w, logic [31:0] l, logic [31:0] k, logic [31:0] d);
    logic [31:0] vals[4];
    vals = '{w, l, k, d};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      model.set_reg(2'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_hashes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending_hashes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] cmd, int t, int f, int d,
                                         logic [31:0] c, logic [31:0] s);
    in_item_t it;
    it.cmd = cmd;
    it.table_index = 4'(t);
    it.func_index = 3'(f);
    it.dim_index = 7'(d);
    it.coef_value = c[15:0];
    it.sample_value = s;
    return it;
  endfunction

  // Returns a load for the first store entry that the next hash would read unwritten.
  function automatic bit find_missing(int nl, int nk, int nd, output in_item_t it);
    for (int k = 0; k < nk; k++)
      if (!model.weight_ok[k]) begin
        it = make_item(CMD_WEIGHT, $urandom, k, $urandom, $urandom, $urandom);
        return 1'b1;
      end
    for (int l = 0; l < nl; l++)
      for (int k = 0; k < nk; k++)
        for (int i = 0; i < nd; i++)
          if (!model.coef_ok[(l * FUNCS_MAX + k) * DIMS_MAX + i]) begin
            it = make_item(CMD_COEF, l, k, i, $urandom, $urandom);
            return 1'b1;
          end
    for (int i = 0; i < nd - 1; i++)
      if (!model.point_ok[i]) begin
        it = make_item(CMD_SAMPLE, $urandom, $urandom, i, $urandom, $urandom);
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic in_item_t random_item(int nl, int nk, int nd);
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      it = make_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 20) begin
      if ($urandom_range(0, 3) == 0)
        it = make_item(CMD_COEF, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        it = make_item(CMD_COEF, $urandom_range(0, nl - 1), $urandom_range(0, nk - 1),
                       $urandom_range(0, nd - 1), $urandom, $urandom);
    end else if (r < 25) begin
      it = make_item(CMD_WEIGHT, $urandom, $urandom_range(0, 7), $urandom, $urandom, $urandom);
    end else begin
      if (r < 30)
        it = make_item(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
      else begin
        it = make_item(CMD_SAMPLE, $urandom, $urandom, seq_dim, $urandom, $urandom);
        seq_dim = (seq_dim + 1) % nd;
      end
      if (it.dim_index == nd - 1) begin
        in_item_t fill;
        if (find_missing(nl, nk, nd, fill)) it = fill;
      end
    end
    return it;
  endfunction

  initial begin
    int phase_w[8], phase_l[8], phase_k[8], phase_d[8], phase_n[8];
    int nl, nk, nd;
    phase_w = '{0, 32'hFFFF_FFFF, 1, $urandom, 65536, $urandom, $urandom_range(1, 4096),
                $urandom};
    phase_l = '{1, 16, 0, 31, 1, 2, 3, 4};
    phase_k = '{1, 1, 8, 15, 1, 3, 2, 4};
    phase_d = '{1, 1, 1, 2, 128, 0, 5, 3};
    phase_n = '{20, 30, 30, 40, 150, 30, 60, 60};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs(32'd65536, 32'd2, 32'd2, 32'd2);
    send_item(make_item(CMD_COEF, 0, 0, 0, 32'sd32767, '0));
    send_item(make_item(CMD_COEF, 0, 0, 1, -32'sd32768, '0));
    send_item(make_item(CMD_COEF, 0, 1, 0, 32'sd16384, '0));
    send_item(make_item(CMD_COEF, 0, 1, 1, -32'sd1, '0));
    send_item(make_item(CMD_COEF, 1, 0, 0, -32'sd16384, '0));
    send_item(make_item(CMD_COEF, 1, 0, 1, 32'sd1, '0));
    send_item(make_item(CMD_COEF, 1, 1, 0, 32'sd0, '0));
    send_item(make_item(CMD_COEF, 1, 1, 1, 32'sd32767, '0));
    send_item(make_item(CMD_WEIGHT, 0, 0, 0, -32'sd32768, '0));
    send_item(make_item(CMD_WEIGHT, 0, 1, 0, 32'sd32767, '0));
    send_item(make_item(CMD_COEF, 15, 7, 127, 32'sd5, 32'hFFFF_FFFF));
    send_item(make_item(CMD_NONE, 15, 7, 127, 32'h0000_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(CMD_SAMPLE, 15, 7, 127, 32'h0000_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(CMD_SAMPLE, 0, 0, 0, '0, 32'h7FFF_FFFF));
    send_item(make_item(CMD_SAMPLE, 0, 0, 1, '0, 32'h8000_0000));
    send_item(make_item(CMD_SAMPLE, 0, 0, 0, '0, 32'hFFFF_FFFF));
    send_item(make_item(CMD_SAMPLE, 0, 0, 1, '0, 32'h0001_0000));
    send_item(make_item(CMD_SAMPLE, 0, 0, 1, '0, 32'h0000_0000));
    drain_hashes();

    for (int p = 0; p < 8; p++) begin
      write_regs(phase_w[p], ($urandom & 32'hFFFF_FFE0) | 32'(phase_l[p]),
                 ($urandom & 32'hFFFF_FFF0) | 32'(phase_k[p]),
                 ($urandom & 32'hFFFF_FF00) | 32'(phase_d[p]));
      nl = model.clamp(phase_l[p] & 31, TABLES_MAX);
      nk = model.clamp(phase_k[p] & 15, FUNCS_MAX);
      nd = model.clamp(phase_d[p] & 255, DIMS_MAX);
      seq_dim = 0;
      in_idling = (p % 3) != 1;
      out_idling = (p % 4) != 2;
      for (int n = 0; n < phase_n[p]; n++) send_item(random_item(nl, nk, nd));
      drain_hashes();
    end
    repeat (200) @(posedge clk);

    $display("Run covered %0d points and %0d hash items over 9 register settings,",
             model.points, model.hashes);
    $display("with random gaps on both channels and %0d mismatches.", model.errors);
    if (model.errors == 0 && model.pending_hashes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
